@@ hw/rtl/tsf_pkg.sv @@
// Shared constants, register codes, state and control types of the touch sample filter.
package tsf_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int WIN_LEN         = 5;
  localparam int CFG_W           = 7;
  localparam int THR_W           = 6;
  localparam int APB_DW          = 32;
  localparam int APB_AW          = 4;

  localparam logic [CFG_W-1:0] WEIGHT_RST  = 7'd1;
  localparam logic [CFG_W-1:0] DIVISOR_RST = 7'd2;
  localparam logic [THR_W-1:0] THRESH_RST  = 6'd5;

  typedef enum logic [1:0] {
    REG_WEIGHT    = 2'd0,
    REG_DIVISOR   = 2'd1,
    REG_THRESHOLD = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MED,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic push;
    logic median;
    logic mult;
    logic sum;
    logic step;
    logic finish;
    logic emit;
  } ctrl_t;

endpackage

@@ hw/rtl/touch_sample_filter_top.sv @@
// Top level of the touch sample filter: configuration registers, sequencer and lanes.
//
// Each request carries a press flag and one X and one Y reading. The X and Y lanes run side by
// side: the reading enters a five-sample window, the median is taken, and a rounding first-order
// smoother is applied unless the debouncer was not yet settled, in which case the median is
// passed straight through. The next request is accepted only once the current one has been
// filtered and moved to the output register; the smoother's divider resolves one quotient
// bit per cycle in each lane. A finished result waits in the output register while the next
// request is taken. There is no clearing pass after reset. Registers: smooth_weight at 0x0,
// smooth_divisor at 0x4, press_threshold at 0x8; a divisor of zero acts as one, and a weight
// above the divisor is clamped to it.
module touch_sample_filter_top #(
  parameter int SAMPLE_BITS = tsf_pkg::SAMPLE_BITS_DEF,
  localparam int DATA_W = ((2 * SAMPLE_BITS + 8) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata fields from bit 0: pressed, raw_x, raw_y, zero padding
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [DATA_W-1:0]           in_tdata,
  // out_tdata fields from bit 0: filt_x, filt_y, press_valid, zero padding
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [DATA_W-1:0]           out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tsf_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [tsf_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [tsf_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int SB = SAMPLE_BITS;
  localparam int STEP_W = $clog2(SB);
  localparam int CW = tsf_pkg::CFG_W;

  tsf_pkg::state_t           state_r;
  tsf_pkg::state_t           state_nxt;
  logic [STEP_W-1:0]         step_r;
  logic [STEP_W-1:0]         step_nxt;
  tsf_pkg::ctrl_t            ctrl;
  logic [CW-1:0]             weight_r;
  logic [CW-1:0]             divisor_r;
  logic [tsf_pkg::THR_W-1:0] thresh_r;
  logic [CW-1:0]             div_eff;
  logic [CW-1:0]             wgt_eff;
  logic                      cfg_wr;
  logic                      load;
  logic                      in_acc;
  logic [SB-1:0]             x_s;
  logic [SB-1:0]             y_s;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r  <= tsf_pkg::WEIGHT_RST;
      divisor_r <= tsf_pkg::DIVISOR_RST;
      thresh_r  <= tsf_pkg::THRESH_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        tsf_pkg::REG_WEIGHT:    weight_r  <= cfg_pwdata[CW-1:0];
        tsf_pkg::REG_DIVISOR:   divisor_r <= cfg_pwdata[CW-1:0];
        tsf_pkg::REG_THRESHOLD: thresh_r  <= cfg_pwdata[tsf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      tsf_pkg::REG_WEIGHT:    cfg_prdata = tsf_pkg::APB_DW'(weight_r);
      tsf_pkg::REG_DIVISOR:   cfg_prdata = tsf_pkg::APB_DW'(divisor_r);
      tsf_pkg::REG_THRESHOLD: cfg_prdata = tsf_pkg::APB_DW'(thresh_r);
      default:                cfg_prdata = '0;
    endcase
  end

  assign div_eff = (divisor_r == '0) ? CW'(1) : divisor_r;
  assign wgt_eff = (weight_r > div_eff) ? div_eff : weight_r;

  assign in_tready = rst_n && (state_r == tsf_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsf_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ctrl      = '0;
    case (state_r)
      tsf_pkg::ST_IDLE: begin
        if (in_acc) begin
          ctrl.push = 1'b1;
          state_nxt = tsf_pkg::ST_MED;
        end
      end
      tsf_pkg::ST_MED: begin
        ctrl.median = 1'b1;
        state_nxt   = tsf_pkg::ST_MUL;
      end
      tsf_pkg::ST_MUL: begin
        ctrl.mult = 1'b1;
        state_nxt = tsf_pkg::ST_SUM;
      end
      tsf_pkg::ST_SUM: begin
        ctrl.sum  = 1'b1;
        step_nxt  = '0;
        state_nxt = tsf_pkg::ST_DIV;
      end
      tsf_pkg::ST_DIV: begin
        ctrl.step = 1'b1;
        step_nxt  = step_r + 1'b1;
        if (step_r == STEP_W'(SB - 1)) begin
          state_nxt = tsf_pkg::ST_FIN;
        end
      end
      tsf_pkg::ST_FIN: begin
        ctrl.finish = 1'b1;
        state_nxt   = tsf_pkg::ST_OUT;
      end
      tsf_pkg::ST_OUT: begin
        if (!out_tvalid || out_tready) begin
          ctrl.emit = 1'b1;
          state_nxt = tsf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tsf_pkg::ST_IDLE;
      end
    endcase
  end

  tsf_lane #(.SAMPLE_BITS(SB)) u_lane_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .load     (load),
    .sample   (in_tdata[SB:1]),
    .weight   (wgt_eff),
    .divisor  (div_eff),
    .smoothed (x_s)
  );

  tsf_lane #(.SAMPLE_BITS(SB)) u_lane_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .load     (load),
    .sample   (in_tdata[2*SB:SB+1]),
    .weight   (wgt_eff),
    .divisor  (div_eff),
    .smoothed (y_s)
  );

  tsf_merge #(.SAMPLE_BITS(SB)) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .pressed    (in_tdata[0]),
    .threshold  (thresh_r),
    .x          (x_s),
    .y          (y_s),
    .load       (load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ hw/rtl/tsf_lane.sv @@
// One channel lane: sample window, median network, smoother and serial divider.
module tsf_lane #(
  parameter int SAMPLE_BITS = tsf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tsf_pkg::ctrl_t              ctrl,
  input  logic                        load,
  input  logic [SAMPLE_BITS-1:0]      sample,
  input  logic [tsf_pkg::CFG_W-1:0]   weight,
  input  logic [tsf_pkg::CFG_W-1:0]   divisor,
  output logic [SAMPLE_BITS-1:0]      smoothed
);

  localparam int SB = SAMPLE_BITS;
  localparam int CW = tsf_pkg::CFG_W;
  localparam int PW = SB + CW;

  logic [SB-1:0] win_r [tsf_pkg::WIN_LEN];
  logic [SB-1:0] t     [tsf_pkg::WIN_LEN];
  logic [SB-1:0] med_r;
  logic [SB-1:0] smoothed_r;
  logic [PW-1:0] p1_r;
  logic [PW-1:0] p2_r;
  logic [PW-1:0] sum_c;
  logic [CW-1:0] rem_r;
  logic [SB-1:0] dvd_r;
  logic [CW:0]   trial;
  logic [CW:0]   diff;
  logic          ge;

  function automatic logic [2*SB-1:0] order_pair(input logic [SB-1:0] a,
                                                 input logic [SB-1:0] b);
    return (a > b) ? {a, b} : {b, a};
  endfunction

  // Fixed nine-step compare-swap network; the median ends up in the middle entry.
  always_comb begin
    for (int i = 0; i < tsf_pkg::WIN_LEN; i++) begin
      t[i] = win_r[i];
    end
    {t[1], t[0]} = order_pair(t[0], t[1]);
    {t[3], t[2]} = order_pair(t[2], t[3]);
    {t[2], t[0]} = order_pair(t[0], t[2]);
    {t[4], t[1]} = order_pair(t[1], t[4]);
    {t[1], t[0]} = order_pair(t[0], t[1]);
    {t[3], t[2]} = order_pair(t[2], t[3]);
    {t[2], t[1]} = order_pair(t[1], t[2]);
    {t[4], t[3]} = order_pair(t[3], t[4]);
    {t[3], t[2]} = order_pair(t[2], t[3]);
  end

  assign sum_c = p1_r + p2_r + PW'(divisor >> 1);
  assign trial = {rem_r, dvd_r[SB-1]};
  assign ge    = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tsf_pkg::WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
      smoothed_r <= '0;
    end else begin
      if (ctrl.push) begin
        for (int i = 0; i < tsf_pkg::WIN_LEN - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[tsf_pkg::WIN_LEN-1] <= sample;
      end
      if (ctrl.finish) begin
        smoothed_r <= load ? med_r : dvd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.median) begin
      med_r <= t[2];
    end
    if (ctrl.mult) begin
      p1_r <= PW'(weight) * PW'(smoothed_r);
      p2_r <= PW'(divisor - weight) * PW'(med_r);
    end
    // The sum stays below divisor times 2^SB, so its top bits already lie below the divisor.
    if (ctrl.sum) begin
      rem_r <= sum_c[PW-1:SB];
      dvd_r <= sum_c[SB-1:0];
    end else if (ctrl.step) begin
      rem_r <= ge ? diff[CW-1:0] : trial[CW-1:0];
      dvd_r <= {dvd_r[SB-2:0], ge};
    end
  end

  assign smoothed = smoothed_r;

endmodule

@@ hw/rtl/tsf_merge.sv @@
// Press debouncer and output register that joins both lanes into one result.
module tsf_merge #(
  parameter int SAMPLE_BITS = tsf_pkg::SAMPLE_BITS_DEF,
  localparam int DATA_W = ((2 * SAMPLE_BITS + 8) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tsf_pkg::ctrl_t              ctrl,
  input  logic                        pressed,
  input  logic [tsf_pkg::THR_W-1:0]   threshold,
  input  logic [SAMPLE_BITS-1:0]      x,
  input  logic [SAMPLE_BITS-1:0]      y,
  output logic                        load,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [DATA_W-1:0]           out_tdata
);

  logic [tsf_pkg::THR_W-1:0] count_r;
  logic [tsf_pkg::THR_W-1:0] count_nxt;
  logic                      valid_r;
  logic                      load_r;
  logic                      out_valid_r;
  logic [DATA_W-1:0]         out_data_r;

  always_comb begin
    count_nxt = count_r;
    if (!pressed) begin
      count_nxt = '0;
    end else if (count_r < threshold) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      valid_r     <= 1'b0;
      load_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.push) begin
        load_r  <= (count_r < threshold);
        count_r <= count_nxt;
        valid_r <= pressed && (count_nxt >= threshold);
      end
      if (ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_data_r <= DATA_W'({valid_r, y, x});
    end
  end

  assign load       = load_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ hw/rtl/tsf_checker.sv @@
// Port-level checks on the touch sample filter, bound to its top level.
module tsf_checker #(
  parameter int SAMPLE_BITS = tsf_pkg::SAMPLE_BITS_DEF,
  localparam int DATA_W = ((2 * SAMPLE_BITS + 8) / 8) * 8
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [DATA_W-1:0]           out_tdata,
  input logic [tsf_pkg::APB_DW-1:0]  cfg_prdata
);

  logic in_acc;

  assign in_acc = in_tvalid && in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or vanished while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second request taken while one is being filtered");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !$rose(out_tvalid) ##1 !$rose(out_tvalid))
    else $error("result appeared before the filter could finish");

  a_reg_width: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_prdata[tsf_pkg::APB_DW-1:tsf_pkg::CFG_W] == '0)
    else $error("register read returned bits above the register width");

endmodule

bind touch_sample_filter_top tsf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tsf_checker (.*);

@@ verif/tb_touch_sample_filter_top.sv @@
// Self-checking testbench for the touch sample filter: stream requests, APB registers, scoreboard.
module tb_touch_sample_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB          = tsf_pkg::SAMPLE_BITS_DEF;
  localparam int DATA_W      = ((2 * SB + 8) / 8) * 8;
  localparam int PAD_W       = DATA_W - 2 * SB - 1;
  localparam int SAMPLE_MAX  = (1 << SB) - 1;
  localparam int TOTAL_REQS  = 1250;
  localparam int IDLE_PCT    = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int END_WAIT    = 3 * (SB + 6);
  localparam int LIMIT       = 500000;
  localparam int NET_LO[9]   = '{0, 2, 0, 1, 0, 2, 1, 3, 2};
  localparam int NET_HI[9]   = '{1, 3, 2, 4, 1, 3, 2, 4, 3};
  localparam logic [tsf_pkg::APB_AW-1:0] ADDR_WEIGHT    = {tsf_pkg::REG_WEIGHT, 2'b00};
  localparam logic [tsf_pkg::APB_AW-1:0] ADDR_DIVISOR   = {tsf_pkg::REG_DIVISOR, 2'b00};
  localparam logic [tsf_pkg::APB_AW-1:0] ADDR_THRESHOLD = {tsf_pkg::REG_THRESHOLD, 2'b00};
  localparam logic [tsf_pkg::APB_AW-1:0] ADDR_UNMAPPED  = 4'hC;

  typedef logic [SB-1:0] sample_t;

  typedef struct packed {
    sample_t x;
    sample_t y;
    logic    press;
  } filt_result_t;

  class filter_scoreboard;
    logic [tsf_pkg::CFG_W-1:0] weight;
    logic [tsf_pkg::CFG_W-1:0] divisor;
    logic [tsf_pkg::THR_W-1:0] threshold;
    sample_t                   x_win[tsf_pkg::WIN_LEN];
    sample_t                   y_win[tsf_pkg::WIN_LEN];
    sample_t                   x_smooth;
    sample_t                   y_smooth;
    logic [tsf_pkg::THR_W-1:0] press_run;
    filt_result_t              pending[$];
    int                        errors;
    int                        results;

    function new();
      weight    = tsf_pkg::WEIGHT_RST;
      divisor   = tsf_pkg::DIVISOR_RST;
      threshold = tsf_pkg::THRESH_RST;
      foreach (x_win[i]) begin
        x_win[i] = '0;
        y_win[i] = '0;
      end
      x_smooth  = '0;
      y_smooth  = '0;
      press_run = '0;
      errors    = 0;
      results   = 0;
    endfunction

    function void flag(string msg);
      if (errors < 10) begin
        $display("mismatch: %s", msg);
      end
      errors++;
    endfunction

    function void write_reg(logic [tsf_pkg::APB_AW-1:0] addr,
                            logic [tsf_pkg::APB_DW-1:0] value);
      case (addr[3:2])
        tsf_pkg::REG_WEIGHT:    weight = value[tsf_pkg::CFG_W-1:0];
        tsf_pkg::REG_DIVISOR:   divisor = value[tsf_pkg::CFG_W-1:0];
        tsf_pkg::REG_THRESHOLD: threshold = value[tsf_pkg::THR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [tsf_pkg::APB_DW-1:0] reg_value(logic [tsf_pkg::APB_AW-1:0] addr);
      case (addr[3:2])
        tsf_pkg::REG_WEIGHT:    return tsf_pkg::APB_DW'(weight);
        tsf_pkg::REG_DIVISOR:   return tsf_pkg::APB_DW'(divisor);
        tsf_pkg::REG_THRESHOLD: return tsf_pkg::APB_DW'(threshold);
        default:                return '0;
      endcase
    endfunction

    function sample_t window_median(sample_t win[tsf_pkg::WIN_LEN]);
      sample_t t[tsf_pkg::WIN_LEN];
      sample_t tmp;
      t = win;
      for (int i = 0; i < 9; i++) begin
        if (t[NET_LO[i]] > t[NET_HI[i]]) begin
          tmp = t[NET_LO[i]];
          t[NET_LO[i]] = t[NET_HI[i]];
          t[NET_HI[i]] = tmp;
        end
      end
      return t[2];
    endfunction

    function sample_t smooth_step(sample_t prev, sample_t med);
      int unsigned d;
      int unsigned w;
      int unsigned acc;
      d = (divisor == 0) ? 1 : divisor;
      w = (weight > d) ? d : weight;
      acc = w * prev + (d - w) * med + d / 2;
      return sample_t'(acc / d);
    endfunction

    function void note_request(logic pressed, sample_t rx, sample_t ry);
      logic         load;
      sample_t      mx;
      sample_t      my;
      filt_result_t r;
      load = !(press_run >= threshold);
      for (int i = 0; i < tsf_pkg::WIN_LEN - 1; i++) begin
        x_win[i] = x_win[i + 1];
        y_win[i] = y_win[i + 1];
      end
      x_win[tsf_pkg::WIN_LEN - 1] = rx;
      y_win[tsf_pkg::WIN_LEN - 1] = ry;
      mx = window_median(x_win);
      my = window_median(y_win);
      x_smooth = load ? mx : smooth_step(x_smooth, mx);
      y_smooth = load ? my : smooth_step(y_smooth, my);
      if (!pressed) begin
        press_run = '0;
        r.press = 1'b0;
      end else begin
        if (press_run < threshold) begin
          press_run = press_run + 1'b1;
        end
        r.press = (press_run >= threshold);
      end
      r.x = x_smooth;
      r.y = y_smooth;
      pending.push_back(r);
    endfunction

    function void check_result(logic [DATA_W-1:0] data);
      filt_result_t e;
      sample_t      gx;
      sample_t      gy;
      logic         gp;
      gx = data[SB-1:0];
      gy = data[2*SB-1:SB];
      gp = data[2*SB];
      results++;
      if (pending.size() == 0) begin
        flag($sformatf("result %0d arrived with no request outstanding", results));
        return;
      end
      e = pending.pop_front();
      if (gx !== e.x) begin
        flag($sformatf("result %0d filt_x expected %0d, got %0d", results, e.x, gx));
      end
      if (gy !== e.y) begin
        flag($sformatf("result %0d filt_y expected %0d, got %0d", results, e.y, gy));
      end
      if (gp !== e.press) begin
        flag($sformatf("result %0d press_valid expected %0d, got %0d", results, e.press, gp));
      end
      if (data[DATA_W-1:2*SB+1] !== '0) begin
        flag($sformatf("result %0d padding expected 0, got %0h", results,
                       data[DATA_W-1:2*SB+1]));
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [DATA_W-1:0]            in_tdata;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [DATA_W-1:0]            out_tdata;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [tsf_pkg::APB_AW-1:0]   cfg_paddr;
  logic [tsf_pkg::APB_DW-1:0]   cfg_pwdata;
  logic [tsf_pkg::APB_DW-1:0]   cfg_prdata;
  logic                         cfg_pready;

  filter_scoreboard sb;
  int               sent;
  int               tx_idle_pct;
  bit               rx_steady;
  bit               hold_req;
  int               hold_left;

  touch_sample_filter_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #6 clk = ~clk;

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // The receiver honours a long hold-off when asked, otherwise stalls at random unless held steady.
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        out_tready = rx_steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  task automatic send_sample(bit pressed, int x, int y);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{PAD_W{1'b0}}, sample_t'(y), sample_t'(x), pressed};
    do @(posedge clk); while (!in_tready);
    sb.note_request(pressed, sample_t'(x), sample_t'(y));
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic check_reg(logic [tsf_pkg::APB_AW-1:0] addr);
    logic [tsf_pkg::APB_DW-1:0] got;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = addr;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (got !== sb.reg_value(addr)) begin
      sb.flag($sformatf("register at %0h read expected %0h, got %0h", addr,
                        sb.reg_value(addr), got));
    end
  endtask

  task automatic program_reg(logic [tsf_pkg::APB_AW-1:0] addr,
                             logic [tsf_pkg::APB_DW-1:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(addr, value);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    if (addr != ADDR_UNMAPPED) begin
      check_reg(addr);
    end
  endtask

  function automatic logic [tsf_pkg::APB_DW-1:0] pick_ratio();
    logic [tsf_pkg::APB_DW-1:0] v;
    case ($urandom_range(7))
      0:       v = 0;
      1:       v = 1;
      2:       v = 64;
      3:       v = 127;
      default: v = $urandom_range(1, 70);
    endcase
    if ($urandom_range(1)) begin
      v = v | ($urandom << tsf_pkg::CFG_W);
    end
    return v;
  endfunction

  function automatic logic [tsf_pkg::APB_DW-1:0] pick_threshold();
    logic [tsf_pkg::APB_DW-1:0] v;
    case ($urandom_range(7))
      0:       v = 0;
      1:       v = 1;
      2:       v = 63;
      default: v = $urandom_range(2, 10);
    endcase
    if ($urandom_range(1)) begin
      v = v | ($urandom << tsf_pkg::THR_W);
    end
    return v;
  endfunction

  task automatic random_config();
    program_reg(ADDR_WEIGHT, pick_ratio());
    program_reg(ADDR_DIVISOR, pick_ratio());
    program_reg(ADDR_THRESHOLD, pick_threshold());
    if ($urandom_range(3) == 0) begin
      program_reg(ADDR_UNMAPPED, $urandom);
    end
  endtask

  function automatic int jitter(int centre, int spread);
    int v;
    v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    if ($urandom_range(19) == 0) begin
      v = $urandom_range(SAMPLE_MAX);
    end
    if (v < 0) begin
      v = 0;
    end
    if (v > SAMPLE_MAX) begin
      v = SAMPLE_MAX;
    end
    return v;
  endfunction

  // One touch: a run of pressed requests around a drifting point, then a short release.
  task automatic touch_stroke();
    int len;
    int bx;
    int by;
    int spread;
    len    = ($urandom_range(9) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 25);
    bx     = $urandom_range(SAMPLE_MAX);
    by     = $urandom_range(SAMPLE_MAX);
    spread = $urandom_range(0, 64);
    for (int i = 0; i < len; i++) begin
      send_sample(1'b1, jitter(bx, spread), jitter(by, spread));
      bx = jitter(bx, 4);
      by = jitter(by, 4);
    end
    repeat ($urandom_range(1, 4)) begin
      send_sample(1'b0, $urandom_range(SAMPLE_MAX), $urandom_range(SAMPLE_MAX));
    end
  endtask

  initial begin
    int phase;
    int phase_start;
    int phase_end;
    bit paused;
    sb          = new();
    sent        = 0;
    tx_idle_pct = IDLE_PCT;
    rx_steady   = 1'b0;
    hold_req    = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    check_reg(ADDR_WEIGHT);
    check_reg(ADDR_DIVISOR);
    check_reg(ADDR_THRESHOLD);

    // Reset settings: full-scale readings, settling of the debouncer, then a release.
    send_sample(1'b1, SAMPLE_MAX, 0);
    send_sample(1'b1, SAMPLE_MAX, 0);
    send_sample(1'b1, 0, SAMPLE_MAX);
    repeat (4) send_sample(1'b1, SAMPLE_MAX, SAMPLE_MAX);
    send_sample(1'b0, 0, 0);
    drain();

    // Weight above the divisor, so the smoothed value holds once settled.
    program_reg(ADDR_WEIGHT, 100);
    program_reg(ADDR_DIVISOR, 10);
    program_reg(ADDR_THRESHOLD, 1);
    send_sample(1'b1, 0, SAMPLE_MAX);
    send_sample(1'b1, SAMPLE_MAX, 0);
    send_sample(1'b1, 1234, 3000);
    send_sample(1'b0, SAMPLE_MAX, SAMPLE_MAX);
    drain();

    // Zero divisor acts as one, and a zero threshold means always settled.
    program_reg(ADDR_WEIGHT, 3);
    program_reg(ADDR_DIVISOR, 0);
    program_reg(ADDR_THRESHOLD, 0);
    send_sample(1'b0, 100, 200);
    send_sample(1'b1, SAMPLE_MAX, 0);
    send_sample(1'b0, 0, SAMPLE_MAX);
    send_sample(1'b1, 2048, 2047);
    drain();

    // A write beyond the register map must leave every register untouched.
    program_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    check_reg(ADDR_WEIGHT);
    check_reg(ADDR_DIVISOR);
    check_reg(ADDR_THRESHOLD);
    program_reg(ADDR_WEIGHT, 64);
    program_reg(ADDR_DIVISOR, 64);
    program_reg(ADDR_THRESHOLD, 63);
    send_sample(1'b1, SAMPLE_MAX, SAMPLE_MAX);
    send_sample(1'b1, 0, 0);
    send_sample(1'b0, 555, 3333);
    send_sample(1'b1, SAMPLE_MAX, 0);
    drain();

    program_reg(ADDR_WEIGHT, 0);
    program_reg(ADDR_DIVISOR, 127);
    program_reg(ADDR_THRESHOLD, 2);
    send_sample(1'b1, 4000, 10);
    send_sample(1'b1, 10, 4000);
    send_sample(1'b1, SAMPLE_MAX, SAMPLE_MAX);
    send_sample(1'b1, 0, 0);

    phase = 0;
    while (sent < TOTAL_REQS) begin
      drain();
      random_config();
      rx_steady   = (phase == 1);
      tx_idle_pct = (phase == 1) ? 0 : IDLE_PCT;
      if (phase == 2) begin
        hold_req = 1'b1;
      end
      phase_start = sent;
      phase_end   = sent + $urandom_range(60, 160);
      paused      = 1'b0;
      while (sent < phase_end && sent < TOTAL_REQS) begin
        if (phase == 3 && !paused && sent >= phase_start + 30) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 15) begin
          send_sample($urandom_range(1), $urandom_range(SAMPLE_MAX), $urandom_range(SAMPLE_MAX));
        end else begin
          touch_stroke();
        end
      end
      phase++;
    end

    drain();
    repeat (END_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
